@@ hdl/fan_curve_overtemp_shutdown_core_defines.svh @@
// ----------------------------------------------------------------------------
// fan curve overtemp shutdown core assertion macros
// concurrent assertion wrappers on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef FAN_CURVE_OVERTEMP_SHUTDOWN_CORE_DEFINES_SVH
`define FAN_CURVE_OVERTEMP_SHUTDOWN_CORE_DEFINES_SVH

`ifndef SYNTH
`define FCOS_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define FCOS_ASSERT_NEXT(name, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);
`else
`define FCOS_ASSERT(name, expr, msg)
`define FCOS_ASSERT_NEXT(name, trig, expr, msg)
`endif

`endif

@@ hdl/fcos_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcos_pkg
// shared types and codes of the fan curve with overtemp shutdown
// ----------------------------------------------------------------------------
package fcos_pkg;

  localparam int NUM_BITS    = 24;
  localparam int SPAN_BITS   = 16;
  localparam int CNT_BITS    = $clog2(NUM_BITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_BITS = 3;

  localparam logic [7:0] DUTY_FULL = 8'd255;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE_TEMP   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TEMP      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_MIN      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_MAX      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALARM_TIME_MS = 3'd4;

  localparam logic [1:0] EV_NONE        = 2'd0;
  localparam logic [1:0] EV_ALARM_START = 2'd1;
  localparam logic [1:0] EV_SHUTDOWN    = 2'd2;
  localparam logic [1:0] EV_ALARM_RESET = 2'd3;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [31:0]        now_ms;
  } in_t;

  typedef struct packed {
    logic [7:0] fan_duty;
    logic       display_on;
    logic [1:0] event_code;
  } out_t;

  typedef struct packed {
    logic signed [14:0] enable_temp;
    logic signed [14:0] max_temp;
    logic [7:0]         duty_min;
    logic [7:0]         duty_max;
    logic [31:0]        alarm_time_ms;
  } cfg_t;

  typedef struct packed {
    logic                 need_div;
    logic [NUM_BITS-1:0]  num;
    logic [SPAN_BITS-1:0] span;
    logic [7:0]           duty;
    logic                 display_on;
    logic [1:0]           event_code;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_PUSH
  } back_state_t;

endpackage

@@ hdl/fcos_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcos_front
// accepts samples, classifies them, keeps alarm state, queues jobs
// ----------------------------------------------------------------------------
module fcos_front #(
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcos_pkg::in_t    in_data,
  input  fcos_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             push,
  output fcos_pkg::job_t   push_data
);
  import fcos_pkg::*;

  localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic                   alarm_active;
  logic [TIME_BITS-1:0]   alarm_start_ms;
  logic                   display_enabled;
  logic                   alarm_active_next;
  logic [TIME_BITS-1:0]   alarm_start_ms_next;
  logic                   display_enabled_next;

  logic signed [14:0]     t;
  logic signed [14:0]     en_t;
  logic signed [14:0]     mx_t;
  logic [CMP_BITS-1:0]    now_wide;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS-1:0]   elapsed;
  logic signed [15:0]     span_s;
  logic signed [15:0]     pos_s;
  logic [15:0]            span_u;
  logic [15:0]            pos_u;
  logic [15:0]            rest_u;
  logic [NUM_BITS-1:0]    p_min;
  logic [NUM_BITS-1:0]    p_max;

  assign t        = in_data.temp_centi;
  assign en_t     = cfg.enable_temp;
  assign mx_t     = cfg.max_temp;
  assign now_wide = CMP_BITS'(in_data.now_ms);
  assign now_t    = now_wide[TIME_BITS-1:0];
  assign elapsed  = now_t - alarm_start_ms;

  assign span_s = {mx_t[14], mx_t} - {en_t[14], en_t};
  assign pos_s  = {t[14], t} - {en_t[14], en_t};
  assign span_u = span_s;
  assign pos_u  = pos_s;
  assign rest_u = span_u - pos_u;
  // dmin*(span-pos) + dmax*pos, both terms unsigned
  assign p_min  = NUM_BITS'(rest_u) * NUM_BITS'(cfg.duty_min);
  assign p_max  = NUM_BITS'(pos_u) * NUM_BITS'(cfg.duty_max);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    alarm_active_next    = alarm_active;
    alarm_start_ms_next  = alarm_start_ms;
    display_enabled_next = display_enabled;
    push_data.need_div   = 1'b0;
    push_data.num        = p_min + p_max;
    push_data.span       = span_u;
    push_data.duty       = 8'd0;
    push_data.event_code = EV_NONE;
    if (t >= en_t) begin
      if (t >= mx_t) begin
        push_data.duty = DUTY_FULL;
        if (alarm_active) begin
          if (CMP_BITS'(elapsed) > CMP_BITS'(cfg.alarm_time_ms)) begin
            display_enabled_next = 1'b0;
            push_data.event_code = EV_SHUTDOWN;
          end
        end else begin
          alarm_active_next    = 1'b1;
          alarm_start_ms_next  = now_t;
          push_data.event_code = EV_ALARM_START;
        end
      end else begin
        push_data.need_div = 1'b1;
        if (alarm_active) begin
          display_enabled_next = 1'b1;
          alarm_active_next    = 1'b0;
          alarm_start_ms_next  = '0;
          push_data.event_code = EV_ALARM_RESET;
        end
      end
    end
    push_data.display_on = display_enabled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_active    <= 1'b0;
      alarm_start_ms  <= '0;
      display_enabled <= 1'b1;
    end else if (push) begin
      alarm_active    <= alarm_active_next;
      alarm_start_ms  <= alarm_start_ms_next;
      display_enabled <= display_enabled_next;
    end
  end

endmodule

@@ hdl/fcos_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcos_queue
// short register queue of jobs between front and back
// ----------------------------------------------------------------------------
module fcos_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fcos_pkg::job_t push_data,
  input  logic           pop,
  output fcos_pkg::job_t pop_data,
  output logic           full,
  output logic           empty
);
  import fcos_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign full     = (count == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hdl/fcos_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcos_back
// serial restoring divider for band duty and the output register
// ----------------------------------------------------------------------------
module fcos_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  fcos_pkg::job_t q_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output fcos_pkg::out_t out_data
);
  import fcos_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  job_t                 job;
  logic [SPAN_BITS-1:0] rem;
  logic [NUM_BITS-1:0]  quo;
  logic [CNT_BITS-1:0]  cnt;
  logic                 load_out;
  logic [SPAN_BITS:0]   shifted;
  logic [SPAN_BITS+1:0] diff;
  logic [7:0]           div_duty;

  assign shifted  = {rem, quo[NUM_BITS-1]};
  assign diff     = {1'b0, shifted} - {2'b00, job.span};
  assign div_duty = (quo[NUM_BITS-1:8] != '0) ? DUTY_FULL : quo[7:0];

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = q_data.need_div ? BK_DIV : BK_PUSH;
        end
      end
      BK_DIV: begin
        if (cnt == CNT_BITS'(NUM_BITS-1)) begin
          state_next = BK_PUSH;
        end
      end
      BK_PUSH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_data;
      quo <= q_data.num;
      rem <= '0;
      cnt <= '0;
    end else if (state == BK_DIV) begin
      cnt <= cnt + 1'b1;
      if (!diff[SPAN_BITS+1]) begin
        rem <= diff[SPAN_BITS-1:0];
        quo <= {quo[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[SPAN_BITS-1:0];
        quo <= {quo[NUM_BITS-2:0], 1'b0};
      end
    end
    if (load_out) begin
      out_data.fan_duty   <= job.need_div ? div_duty : job.duty;
      out_data.display_on <= job.display_on;
      out_data.event_code <= job.event_code;
    end
  end

endmodule

@@ hdl/fan_curve_overtemp_shutdown_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_curve_overtemp_shutdown_core
// linear fan curve with overtemp alarm and display shutdown
//
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  temp_centi, now_ms
// out      output     out_valid/out_ready  fan_duty, display_on, event_code
// cfg      input      cfg_wen              cfg_index, cfg_data
//
// a sample between the thresholds passes through the 24 step serial divider
// in the back end; any other sample skips the divider and goes straight to push
// the front accepts while the two entry queue has room, even during a divide
// rst is synchronous and returns thresholds, alarm and display to defaults
// a stalled output holds its result and backs up the queue, then in_ready
// ----------------------------------------------------------------------------
`include "fan_curve_overtemp_shutdown_core_defines.svh"

module fan_curve_overtemp_shutdown_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fcos_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fcos_pkg::out_t                      out_data,
  input  logic                                cfg_wen,
  input  logic [fcos_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [31:0]                         cfg_data
);
  import fcos_pkg::*;

  cfg_t cfg;
  job_t push_data;
  job_t q_data;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_temp   <= 15'sd3000;
      cfg.max_temp      <= 15'sd5000;
      cfg.duty_min      <= 8'd64;
      cfg.duty_max      <= 8'd255;
      cfg.alarm_time_ms <= 32'd60000;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_ENABLE_TEMP:   cfg.enable_temp   <= cfg_data[14:0];
        REG_MAX_TEMP:      cfg.max_temp      <= cfg_data[14:0];
        REG_DUTY_MIN:      cfg.duty_min      <= cfg_data[7:0];
        REG_DUTY_MAX:      cfg.duty_max      <= cfg_data[7:0];
        REG_ALARM_TIME_MS: cfg.alarm_time_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fcos_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  fcos_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  fcos_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `FCOS_ASSERT_NEXT(a_accept_queued, in_valid && in_ready, !q_empty, "accepted sample not queued")
  `FCOS_ASSERT(a_shutdown_dark, !(out_valid && out_data.event_code == EV_SHUTDOWN) || !out_data.display_on, "shutdown with display on")
  `FCOS_ASSERT(a_start_lit, !(out_valid && (out_data.event_code == EV_ALARM_START || out_data.event_code == EV_ALARM_RESET)) || out_data.display_on, "alarm start or reset with display off")

endmodule
